@@ hw/rtl/mcpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpd_pkg
// Shared types and constants for the multichannel packet deframer.
// ----------------------------------------------------------------------------
package mcpd_pkg;

    localparam int NUM_CHANNELS = 3;
    localparam int ADDR_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CHAN_W       = 2;
    localparam int BYTE_BITS    = 8;
    localparam int WORD_W       = 2 * BYTE_BITS;

    localparam logic [BYTE_BITS-1:0] SYNC_BYTE = 8'hFF;

    typedef enum logic [3:0] {
        PH_HUNT0   = 4'd0,
        PH_HUNT1   = 4'd1,
        PH_CMD1_LO = 4'd2,
        PH_CMD1_HI = 4'd3,
        PH_CMD2_LO = 4'd4,
        PH_CMD2_HI = 4'd5,
        PH_LEN_LO  = 4'd6,
        PH_LEN_HI  = 4'd7,
        PH_PAYLOAD = 4'd8
    } phase_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    channel;
        logic [BYTE_BITS-1:0] byte_value;
    } item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]    out_channel;
        logic [WORD_W-1:0]    command_one;
        logic [WORD_W-1:0]    command_two;
        logic [WORD_W-1:0]    frame_length;
        logic [BYTE_BITS-1:0] payload_byte;
        logic [WORD_W-1:0]    byte_index;
        logic                 has_byte;
        logic                 last;
    } result_t;

    typedef struct packed {
        phase_t            phase;
        logic [WORD_W-1:0] command_one;
        logic [WORD_W-1:0] command_two;
        logic [WORD_W-1:0] length;
        logic [WORD_W-1:0] count;
    } chan_state_t;

endpackage

@@ hw/rtl/multichannel_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// multichannel_packet_deframer
// Per-channel sync/header/length parser that streams out payload bytes.
// ----------------------------------------------------------------------------
// input channel: item (channel, byte_value) with item_valid / item_ready.
// each channel runs its own parser: two 0xff sync bytes, command word one,
// command word two and a length, all 16-bit little-endian, then the payload.
// output channel: result with result_valid / result_ready. one result per
// payload byte (last marks the final byte) and one empty notice with
// has_byte low for a zero-length frame; other bytes give no result.
// bytes with a channel number of the channel count or more are dropped.
// throughput: one byte per cycle unless a stalled result holds stage one.
// the per-channel state lives in a small synchronous memory; each byte
// does one read and one write-back, and a byte on the same channel as the
// one ahead takes its state from a bypass register instead of the memory.
// a result passes through the stage-one register, then the output register.
// reset: every channel starts hunting for sync with zeroed header fields;
// per-entry valid bits make a never-written entry read as zero, so no
// clearing pass is needed.
// stall: a waiting result sits in the output register; requests keep
// flowing until a second result would need that register.
// ----------------------------------------------------------------------------
module multichannel_packet_deframer
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  mcpd_pkg::item_t  item,
    output logic             result_valid,
    input  logic             result_ready,
    output mcpd_pkg::result_t result
);

    mcpd_pkg::chan_state_t state_mem [mcpd_pkg::NUM_CHANNELS];
    logic [mcpd_pkg::NUM_CHANNELS-1:0] entry_valid_reg;

    mcpd_pkg::chan_state_t rd_data_reg;
    logic                  rd_valid_reg;
    mcpd_pkg::chan_state_t fwd_data_reg;
    logic                  fwd_valid_reg;

    logic                                s1_valid_reg;
    logic [mcpd_pkg::ADDR_W-1:0]         s1_ch_reg;
    logic [mcpd_pkg::BYTE_BITS-1:0]      s1_byte_reg;

    logic              result_valid_reg;
    mcpd_pkg::result_t result_reg;

    mcpd_pkg::chan_state_t cur;
    mcpd_pkg::chan_state_t entry_next;
    mcpd_pkg::result_t     res;
    logic                  has_result;
    logic [mcpd_pkg::WORD_W-1:0] len_full;
    logic                  fin;
    logic                  s1_adv;
    logic                  accept;
    logic                  in_range;
    logic [mcpd_pkg::ADDR_W-1:0] rd_addr;
    logic                  load_out;

    assign in_range = int'(item.channel) < mcpd_pkg::NUM_CHANNELS;
    assign rd_addr  = mcpd_pkg::ADDR_W'(item.channel);

    assign s1_adv     = !(has_result && result_valid_reg && !result_ready);
    assign item_ready = !s1_valid_reg || s1_adv;
    assign accept     = item_valid && item_ready;
    assign load_out   = s1_valid_reg && s1_adv && has_result;

    // channel state as seen by the byte in stage one
    always_comb
    begin
        if (fwd_valid_reg)
        begin
            cur = fwd_data_reg;
        end
        else if (rd_valid_reg)
        begin
            cur = rd_data_reg;
        end
        else
        begin
            cur = '0;
        end
    end

    assign len_full = {s1_byte_reg, cur.length[mcpd_pkg::BYTE_BITS-1:0]};
    assign fin = ({1'b0, cur.count} + 17'd1) >= {1'b0, cur.length};

    // next state
    always_comb
    begin
        entry_next = cur;
        unique case (cur.phase)
            mcpd_pkg::PH_HUNT1:
            begin
                entry_next.phase = (s1_byte_reg == mcpd_pkg::SYNC_BYTE) ?
                                   mcpd_pkg::PH_CMD1_LO : mcpd_pkg::PH_HUNT0;
            end
            mcpd_pkg::PH_CMD1_LO:
            begin
                entry_next.command_one = {8'h00, s1_byte_reg};
                entry_next.phase       = mcpd_pkg::PH_CMD1_HI;
            end
            mcpd_pkg::PH_CMD1_HI:
            begin
                entry_next.command_one =
                    {s1_byte_reg, cur.command_one[mcpd_pkg::BYTE_BITS-1:0]};
                entry_next.phase       = mcpd_pkg::PH_CMD2_LO;
            end
            mcpd_pkg::PH_CMD2_LO:
            begin
                entry_next.command_two = {8'h00, s1_byte_reg};
                entry_next.phase       = mcpd_pkg::PH_CMD2_HI;
            end
            mcpd_pkg::PH_CMD2_HI:
            begin
                entry_next.command_two =
                    {s1_byte_reg, cur.command_two[mcpd_pkg::BYTE_BITS-1:0]};
                entry_next.phase       = mcpd_pkg::PH_LEN_LO;
            end
            mcpd_pkg::PH_LEN_LO:
            begin
                entry_next.length = {8'h00, s1_byte_reg};
                entry_next.phase  = mcpd_pkg::PH_LEN_HI;
            end
            mcpd_pkg::PH_LEN_HI:
            begin
                entry_next.length = len_full;
                entry_next.count  = '0;
                entry_next.phase  = (len_full == '0) ?
                                    mcpd_pkg::PH_HUNT0 : mcpd_pkg::PH_PAYLOAD;
            end
            mcpd_pkg::PH_PAYLOAD:
            begin
                entry_next.count = cur.count + 16'd1;
                if (fin)
                begin
                    entry_next.phase = mcpd_pkg::PH_HUNT0;
                end
            end
            default:
            begin
                entry_next.count = '0;
                entry_next.phase = (s1_byte_reg == mcpd_pkg::SYNC_BYTE) ?
                                   mcpd_pkg::PH_HUNT1 : mcpd_pkg::PH_HUNT0;
            end
        endcase
    end

    // result
    always_comb
    begin
        has_result       = 1'b0;
        res.out_channel  = mcpd_pkg::CHAN_W'(s1_ch_reg);
        res.command_one  = cur.command_one;
        res.command_two  = cur.command_two;
        res.frame_length = cur.length;
        res.payload_byte = '0;
        res.byte_index   = '0;
        res.has_byte     = 1'b0;
        res.last         = 1'b0;
        unique case (cur.phase)
            mcpd_pkg::PH_LEN_HI:
            begin
                if (len_full == '0)
                begin
                    has_result       = 1'b1;
                    res.frame_length = len_full;
                    res.last         = 1'b1;
                end
            end
            mcpd_pkg::PH_PAYLOAD:
            begin
                has_result       = 1'b1;
                res.payload_byte = s1_byte_reg;
                res.byte_index   = cur.count;
                res.has_byte     = 1'b1;
                res.last         = fin;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // state memory
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_adv)
        begin
            state_mem[s1_ch_reg] <= entry_next;
        end
        if (accept && in_range)
        begin
            rd_data_reg <= state_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            rd_valid_reg    <= 1'b0;
            fwd_valid_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (s1_valid_reg && s1_adv)
            begin
                entry_valid_reg[s1_ch_reg] <= 1'b1;
            end
            if (accept)
            begin
                s1_valid_reg <= in_range;
                if (in_range)
                begin
                    rd_valid_reg  <= entry_valid_reg[rd_addr];
                    fwd_valid_reg <= s1_valid_reg && (s1_ch_reg == rd_addr);
                end
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage one payload and bypass
    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            s1_ch_reg    <= rd_addr;
            s1_byte_reg  <= item.byte_value;
            fwd_data_reg <= entry_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

@@ hw/rtl/mcpd_checker.sv @@
// ----------------------------------------------------------------------------
// mcpd_checker
// Port-level checks for the multichannel packet deframer.
// ----------------------------------------------------------------------------
module mcpd_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic              result_ready,
    input mcpd_pkg::result_t result
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result dropped or changed");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_byte |-> result.last)
        else $error("empty frame notice not marked last");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.has_byte |->
            result.payload_byte == '0 && result.byte_index == '0 &&
            result.frame_length == '0)
        else $error("empty frame notice carries data");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.has_byte |-> result.byte_index < result.frame_length)
        else $error("byte index beyond frame length");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.has_byte |->
            (result.last == (({1'b0, result.byte_index} + 17'd1) ==
                             {1'b0, result.frame_length})))
        else $error("last flag does not match final byte");

endmodule

bind multichannel_packet_deframer mcpd_checker u_mcpd_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
